/* src/sfbr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbr_pkg
// Shared types and constants of the stuffed frame bit receiver.
// ----------------------------------------------------------------------------
package sfbr_pkg;

  // Frame layout and bit masks
  localparam logic [7:0] END_MARK     = 8'h7E;  // end byte that may request an ack
  localparam logic [3:0] LEN_LIMIT    = 4'd13;  // largest legal data count
  localparam logic [7:0] MASK_FIRST   = 8'h80;  // MSB first
  localparam logic [7:0] MASK_SOF     = 8'h02;  // two-bit start field
  localparam logic [7:0] MASK_RESP    = 8'h1F;  // response ends after three bits
  localparam logic [4:0] POS_SAT      = 5'd31;  // byte position saturates here
  localparam logic [4:0] POS_LEN      = 5'd1;   // position of the length byte
  localparam logic [4:0] POS_DEST     = 5'd2;   // position of the destination ID
  localparam logic [2:0] RUN_STUFF    = 3'd5;   // equal bits before a stuff bit
  localparam logic [2:0] RUN_SAT      = 3'd7;

  // Configuration register indexes and reset values
  localparam logic       CFG_CRC_POLY = 1'b0;
  localparam logic       CFG_ACK_IDS  = 1'b1;
  localparam logic [7:0] CRC_POLY_RST = 8'h13;

  // One result beat
  typedef struct packed {
    logic [7:0] byte_value;
    logic [4:0] byte_pos;
    logic       last;
    logic       aborted;
    logic       crc_ok;
    logic       ack_wanted;
  } rx_beat_t;

endpackage

/* src/stuffed_frame_bit_receiver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_bit_receiver_core
// Bit-stuffed serial frame receiver with CRC-8 check and ack request.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one beat per event. in_cmd = 0 is a
// pin change or idle check; a high in_rx_bit then starts a frame when idle.
// in_cmd = 1 is a bit time sample. Bits are assembled MSB first into the
// start field, length byte, data bytes and CRC byte (stuff bits dropped),
// then the end byte and a three-bit response field.
// Output channel (out_valid / out_stall): one beat per completed byte, with
// its frame position, last/aborted flags and, on the end byte, the CRC
// verdict and ack request.
// Config channel (cfg_valid / cfg_ready): index 0 is the CRC-8 polynomial,
// index 1 the packed ack ID bytes. Write only while the block is idle.
// A result is registered and appears on out_* in the cycle after the beat
// that completes the byte. One input beat per cycle while in_stall is low;
// the frame state and the CRC are updated in the same cycle the beat is taken.
// in_stall rises only while a result waits and out_stall is high; a waiting
// result holds its payload until it is taken.
// Reset: the receiver is idle, no result is pending, the polynomial is 0x13
// and all ack IDs are zero.
// ----------------------------------------------------------------------------
module stuffed_frame_bit_receiver_core #(
  parameter int ACK_ID_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  // config write
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  // input beats
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_cmd,
  input  logic        in_rx_bit,
  // result beats
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_value,
  output logic [4:0]  out_byte_pos,
  output logic        out_last,
  output logic        out_aborted,
  output logic        out_crc_ok,
  output logic        out_ack_wanted
);

  localparam int IdW = 8 * ACK_ID_SLOTS;

  typedef enum logic [2:0] {
    ST_START,
    ST_LEN,
    ST_DATA,
    ST_CRC,
    ST_END,
    ST_RESP
  } stage_t;

  // MSB-first CRC-8 over one byte
  function automatic logic [7:0] crc8_step(input logic [7:0] crc, input logic [7:0] b,
                                           input logic [7:0] poly);
    logic [7:0] x;
    x = crc ^ b;
    for (int n = 0; n < 8; n++) begin
      x = x[7] ? ({x[6:0], 1'b0} ^ poly) : {x[6:0], 1'b0};
    end
    return x;
  endfunction

  // Config and frame state
  logic [7:0]         crc_poly_r;
  logic [IdW-1:0]     ack_ids_r;
  logic               listening_r, listening_nxt;
  stage_t             stage_r, stage_nxt;
  logic [7:0]         shift_r, shift_nxt;
  logic [7:0]         mask_r, mask_nxt;
  logic [2:0]         ones_r, ones_nxt;
  logic [2:0]         zeros_r, zeros_nxt;
  logic [3:0]         left_r, left_nxt;
  logic [4:0]         count_r, count_nxt;
  logic [7:0]         crc_r, crc_nxt;
  logic [7:0]         dest_r, dest_nxt;
  logic               out_valid_r, out_valid_nxt;
  sfbr_pkg::rx_beat_t out_beat_r;

  // Step signals
  logic               load;
  logic               accept;
  logic               res_vld;
  sfbr_pkg::rx_beat_t res;
  logic               drop;
  logic [7:0]         sh_bit;
  logic [7:0]         mk_bit;
  logic [7:0]         crc_new;
  logic               id_hit;
  logic [3:0]         left_dec;

  // Handshakes: output register drains or is empty -> take a beat
  assign cfg_ready = 1'b1;
  assign load      = !out_valid_r || !out_stall;
  assign in_stall  = !load;
  assign accept    = in_valid && load;

  // Destination ID lookup
  always_comb begin
    id_hit = 1'b0;
    for (int a = 0; a < ACK_ID_SLOTS; a++) begin
      if (ack_ids_r[8*a +: 8] == dest_r) id_hit = 1'b1;
    end
  end

  // Bit assembly with stuff-bit removal
  always_comb begin
    drop   = (stage_r == ST_LEN || stage_r == ST_DATA || stage_r == ST_CRC) &&
             (ones_r == sfbr_pkg::RUN_STUFF || zeros_r == sfbr_pkg::RUN_STUFF);
    sh_bit = drop ? shift_r : (shift_r | (in_rx_bit ? mask_r : 8'h00));
    mk_bit = drop ? mask_r : {1'b0, mask_r[7:1]};
    crc_new  = crc8_step(crc_r, sh_bit, crc_poly_r);
    left_dec = (left_r != 4'd0) ? left_r - 4'd1 : left_r;
  end

  // Frame sequencer
  always_comb begin
    listening_nxt = listening_r;
    stage_nxt     = stage_r;
    shift_nxt     = shift_r;
    mask_nxt      = mask_r;
    ones_nxt      = ones_r;
    zeros_nxt     = zeros_r;
    left_nxt      = left_r;
    count_nxt     = count_r;
    crc_nxt       = crc_r;
    dest_nxt      = dest_r;
    res_vld       = 1'b0;
    res           = '0;
    res.byte_value = sh_bit;
    res.byte_pos   = count_r;

    if (accept) begin
      if (!in_cmd) begin
        // idle check: a high level opens a frame
        if (!listening_r && in_rx_bit) begin
          listening_nxt = 1'b1;
          stage_nxt     = ST_START;
          shift_nxt     = 8'h00;
          mask_nxt      = sfbr_pkg::MASK_SOF;
          ones_nxt      = 3'd0;
          zeros_nxt     = 3'd0;
          left_nxt      = 4'd0;
          count_nxt     = 5'd0;
          crc_nxt       = 8'h00;
          dest_nxt      = 8'h00;
        end
      end else if (listening_r) begin
        shift_nxt = sh_bit;
        mask_nxt  = mk_bit;
        // run counters in stuffed fields
        if (stage_r == ST_LEN || stage_r == ST_DATA || stage_r == ST_CRC) begin
          if (in_rx_bit) begin
            ones_nxt  = (ones_r < sfbr_pkg::RUN_SAT) ? ones_r + 3'd1 : ones_r;
            zeros_nxt = 3'd0;
          end else begin
            zeros_nxt = (zeros_r < sfbr_pkg::RUN_SAT) ? zeros_r + 3'd1 : zeros_r;
            ones_nxt  = 3'd0;
          end
        end
        // byte complete?
        if (stage_r == ST_RESP) begin
          res_vld = (mk_bit == 8'h00) || ((mk_bit & sfbr_pkg::MASK_RESP) != 8'h00);
        end else begin
          res_vld = (mk_bit == 8'h00);
        end

        unique case (stage_r)
          ST_START: begin
            if (res_vld) begin
              stage_nxt      = ST_LEN;
              res.byte_value = {7'd0, sh_bit[0]};
            end
          end
          ST_LEN: begin
            if (res_vld) begin
              crc_nxt  = crc_new;
              left_nxt = sh_bit[3:0];
              if (sh_bit[3:0] > sfbr_pkg::LEN_LIMIT) begin
                res.last      = 1'b1;
                res.aborted   = 1'b1;
                listening_nxt = 1'b0;
                stage_nxt     = ST_START;
              end else begin
                stage_nxt = (sh_bit[3:0] != 4'd0) ? ST_DATA : ST_CRC;
              end
            end
          end
          ST_DATA: begin
            if (res_vld) begin
              if (count_r == sfbr_pkg::POS_DEST) dest_nxt = sh_bit;
              crc_nxt  = crc_new;
              left_nxt = left_dec;
              if (left_dec == 4'd0) stage_nxt = ST_CRC;
            end
          end
          ST_CRC: begin
            if (res_vld) begin
              if (count_r == sfbr_pkg::POS_DEST) dest_nxt = sh_bit;
              crc_nxt   = crc_new;
              ones_nxt  = 3'd0;
              zeros_nxt = 3'd0;
              stage_nxt = ST_END;
            end
          end
          ST_END: begin
            if (res_vld) begin
              stage_nxt      = ST_RESP;
              res.crc_ok     = (crc_r == 8'h00);
              res.ack_wanted = (sh_bit == sfbr_pkg::END_MARK) && id_hit;
            end
          end
          ST_RESP: begin
            if (res_vld) begin
              res.last      = 1'b1;
              listening_nxt = 1'b0;
              stage_nxt     = ST_START;
            end
          end
          default: begin
            // undefined stage code: back to idle, bit discarded
            res_vld       = 1'b0;
            shift_nxt     = shift_r;
            mask_nxt      = mask_r;
            ones_nxt      = ones_r;
            zeros_nxt     = zeros_r;
            listening_nxt = 1'b0;
            stage_nxt     = ST_START;
          end
        endcase

        // common emit bookkeeping
        if (res_vld) begin
          count_nxt = (count_r < sfbr_pkg::POS_SAT) ? count_r + 5'd1 : count_r;
          shift_nxt = 8'h00;
          mask_nxt  = sfbr_pkg::MASK_FIRST;
        end
      end
    end

    // output register
    out_valid_nxt = load ? (accept && res_vld) : out_valid_r;
  end

  // State, config and result registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_poly_r  <= sfbr_pkg::CRC_POLY_RST;
      ack_ids_r   <= '0;
      listening_r <= 1'b0;
      stage_r     <= ST_START;
      shift_r     <= 8'h00;
      mask_r      <= sfbr_pkg::MASK_FIRST;
      ones_r      <= 3'd0;
      zeros_r     <= 3'd0;
      left_r      <= 4'd0;
      count_r     <= 5'd0;
      crc_r       <= 8'h00;
      dest_r      <= 8'h00;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          sfbr_pkg::CFG_CRC_POLY: crc_poly_r <= cfg_data[7:0];
          sfbr_pkg::CFG_ACK_IDS:  ack_ids_r  <= cfg_data[IdW-1:0];
          default: ;
        endcase
      end
      listening_r <= listening_nxt;
      stage_r     <= stage_nxt;
      shift_r     <= shift_nxt;
      mask_r      <= mask_nxt;
      ones_r      <= ones_nxt;
      zeros_r     <= zeros_nxt;
      left_r      <= left_nxt;
      count_r     <= count_nxt;
      crc_r       <= crc_nxt;
      dest_r      <= dest_nxt;
      out_valid_r <= out_valid_nxt;
    end
    // payload needs no reset
    if (accept && res_vld) out_beat_r <= res;
  end

  assign out_valid      = out_valid_r;
  assign out_byte_value = out_beat_r.byte_value;
  assign out_byte_pos   = out_beat_r.byte_pos;
  assign out_last       = out_beat_r.last;
  assign out_aborted    = out_beat_r.aborted;
  assign out_crc_ok     = out_beat_r.crc_ok;
  assign out_ack_wanted = out_beat_r.ack_wanted;

endmodule

/* src/sfbr_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfbr_checker
// Port-level checks of the stuffed frame bit receiver, bound to the core.
// ----------------------------------------------------------------------------
module sfbr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_stall,
  input logic       out_valid,
  input logic       out_stall,
  input logic [7:0] out_byte_value,
  input logic [4:0] out_byte_pos,
  input logic       out_last,
  input logic       out_aborted,
  input logic       out_crc_ok,
  input logic       out_ack_wanted
);

  // A stalled result beat stays and holds its value, position and last/aborted flags
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_byte_value) &&
      $stable(out_byte_pos) && $stable(out_last) && $stable(out_aborted))
    else $error("stalled result beat changed");

  // Input is only held off by a waiting, stalled result
  a_in_free: assert property (@(posedge clk) disable iff (!rst_n)
    !(out_valid && out_stall) |-> !in_stall)
    else $error("input stalled with output free");

  // An abort happens on the length byte and closes the frame
  a_abort: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_aborted |-> out_last && out_byte_pos == sfbr_pkg::POS_LEN)
    else $error("abort beat malformed");

  // CRC verdict and ack request, set only on the end byte, never on a closing beat
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_crc_ok || out_ack_wanted) |-> !out_last && !out_aborted)
    else $error("verdict flags on wrong beat");

  // The start field beat carries a single bit
  a_start: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_byte_pos == 5'd0 |-> out_byte_value[7:1] == 7'd0)
    else $error("start field beat wider than one bit");

endmodule

bind stuffed_frame_bit_receiver_core sfbr_checker u_sfbr_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_stall       (in_stall),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_byte_value (out_byte_value),
  .out_byte_pos   (out_byte_pos),
  .out_last       (out_last),
  .out_aborted    (out_aborted),
  .out_crc_ok     (out_crc_ok),
  .out_ack_wanted (out_ack_wanted)
);

/* verif/stuffed_frame_bit_receiver_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// stuffed_frame_bit_receiver_checker
// Watches the config, input and result channels of the receiver. It keeps its
// own copy of the frame state, works out the byte that each accepted input
// beat completes, and compares every result beat field by field, in order.
// ----------------------------------------------------------------------------
module stuffed_frame_bit_receiver_checker #(
  parameter int ACK_ID_SLOTS = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic        in_cmd,
  input  logic        in_rx_bit,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [7:0]  out_byte_value,
  input  logic [4:0]  out_byte_pos,
  input  logic        out_last,
  input  logic        out_aborted,
  input  logic        out_crc_ok,
  input  logic        out_ack_wanted,
  output int          fail_count,
  output int          results_owed,
  output int          bytes_checked,
  output logic        frame_open
);

  typedef enum logic [2:0] {
    ST_SOF, ST_LEN, ST_DATA, ST_CRC, ST_END, ST_RESP
  } rx_stage_t;

  // register mirror
  logic [7:0]  poly_reg;
  logic [63:0] ack_id_set;

  // frame state mirror
  logic        rx_open;
  rx_stage_t   rx_stage;
  logic [7:0]  shift_reg;
  logic [7:0]  bit_sel;
  logic [2:0]  run_ones;
  logic [2:0]  run_zeros;
  logic [3:0]  data_left;
  logic [4:0]  frame_pos;
  logic [7:0]  crc_run;
  logic [7:0]  dest_byte;

  sfbr_pkg::rx_beat_t pending_bytes[$];
  int          mismatches = 0;
  int          matched = 0;

  // MSB-first CRC-8, init 0, one byte at a time
  function automatic logic [7:0] crc8_next(logic [7:0] crc, logic [7:0] b);
    logic [7:0] x;
    x = crc ^ b;
    for (int n = 0; n < 8; n++) begin
      if (x[7]) x = (x << 1) ^ poly_reg;
      else      x = x << 1;
    end
    return x;
  endfunction

  function automatic logic id_listed(logic [7:0] id);
    for (int a = 0; a < ACK_ID_SLOTS && a < 8; a++) begin
      if (ack_id_set[8*a +: 8] == id) return 1'b1;
    end
    return 1'b0;
  endfunction

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      mismatches++;
    end
  endtask

  // Advance the frame state by one input beat; queue the byte it completes
  task automatic receive_event(input logic cmd, input logic lvl);
    sfbr_pkg::rx_beat_t beat;
    logic [7:0] v;
    logic       done;
    beat = '0;
    done = 1'b0;
    if (!cmd) begin
      // high level on an idle bus opens a frame; ignored while listening
      if (!rx_open && lvl) begin
        rx_open   = 1'b1;
        rx_stage  = ST_SOF;
        shift_reg = '0;
        bit_sel   = sfbr_pkg::MASK_SOF;
        run_ones  = '0;
        run_zeros = '0;
        data_left = '0;
        frame_pos = '0;
        crc_run   = '0;
        dest_byte = '0;
      end
    end else if (rx_open) begin
      if (rx_stage == ST_LEN || rx_stage == ST_DATA || rx_stage == ST_CRC) begin
        // stuffed region: the bit after five equal bits is dropped
        if (run_ones != sfbr_pkg::RUN_STUFF && run_zeros != sfbr_pkg::RUN_STUFF) begin
          if (lvl) shift_reg = shift_reg | bit_sel;
          bit_sel = bit_sel >> 1;
        end
        if (lvl) begin
          if (run_ones != sfbr_pkg::RUN_SAT) run_ones = run_ones + 3'd1;
          run_zeros = '0;
        end else begin
          if (run_zeros != sfbr_pkg::RUN_SAT) run_zeros = run_zeros + 3'd1;
          run_ones = '0;
        end
      end else begin
        if (lvl) shift_reg = shift_reg | bit_sel;
        bit_sel = bit_sel >> 1;
      end
      v = shift_reg;

      case (rx_stage)
        ST_SOF: if (bit_sel == '0) begin
          beat.byte_value = {7'd0, v[0]};
          rx_stage = ST_LEN;
          done = 1'b1;
        end
        ST_LEN: if (bit_sel == '0) begin
          crc_run = crc8_next(crc_run, v);
          data_left = v[3:0];
          beat.byte_value = v;
          done = 1'b1;
          if (data_left > sfbr_pkg::LEN_LIMIT) begin
            beat.last    = 1'b1;
            beat.aborted = 1'b1;
            rx_open  = 1'b0;
            rx_stage = ST_SOF;
          end else if (data_left != '0) begin
            rx_stage = ST_DATA;
          end else begin
            rx_stage = ST_CRC;
          end
        end
        ST_DATA: if (bit_sel == '0) begin
          if (frame_pos == sfbr_pkg::POS_DEST) dest_byte = v;
          crc_run = crc8_next(crc_run, v);
          if (data_left != '0) data_left = data_left - 4'd1;
          if (data_left == '0) rx_stage = ST_CRC;
          beat.byte_value = v;
          done = 1'b1;
        end
        ST_CRC: if (bit_sel == '0) begin
          // with a zero count the CRC byte sits at the destination position
          if (frame_pos == sfbr_pkg::POS_DEST) dest_byte = v;
          crc_run = crc8_next(crc_run, v);
          run_ones  = '0;
          run_zeros = '0;
          rx_stage  = ST_END;
          beat.byte_value = v;
          done = 1'b1;
        end
        ST_END: if (bit_sel == '0) begin
          beat.byte_value = v;
          beat.crc_ok     = (crc_run == '0);
          beat.ack_wanted = (v == sfbr_pkg::END_MARK) && id_listed(dest_byte);
          rx_stage = ST_RESP;
          done = 1'b1;
        end
        default: if (bit_sel == '0 || (bit_sel & sfbr_pkg::MASK_RESP) != '0) begin
          // response field: three bits, then back to idle
          beat.byte_value = v;
          beat.last = 1'b1;
          rx_open  = 1'b0;
          rx_stage = ST_SOF;
          done = 1'b1;
        end
      endcase

      if (done) begin
        beat.byte_pos = frame_pos;
        if (frame_pos != sfbr_pkg::POS_SAT) frame_pos = frame_pos + 5'd1;
        shift_reg = '0;
        bit_sel   = sfbr_pkg::MASK_FIRST;
        pending_bytes.push_back(beat);
      end
    end
  endtask

  always @(posedge clk) begin
    sfbr_pkg::rx_beat_t want;
    if (!rst_n) begin
      poly_reg   = sfbr_pkg::CRC_POLY_RST;
      ack_id_set = '0;
      rx_open    = 1'b0;
      rx_stage   = ST_SOF;
      shift_reg  = '0;
      bit_sel    = sfbr_pkg::MASK_FIRST;
      run_ones   = '0;
      run_zeros  = '0;
      data_left  = '0;
      frame_pos  = '0;
      crc_run    = '0;
      dest_byte  = '0;
      pending_bytes.delete();
    end else begin
      // register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == sfbr_pkg::CFG_CRC_POLY) poly_reg = cfg_data[7:0];
        else                                     ack_id_set = cfg_data;
      end

      // result beat against the oldest expected byte
      if (out_valid && !out_stall) begin
        if (pending_bytes.size() == 0) begin
          $error("result beat with nothing expected: byte 0x%0h at pos %0d",
                 out_byte_value, out_byte_pos);
          mismatches++;
        end else begin
          want = pending_bytes.pop_front();
          check_field("byte_value", want.byte_value, out_byte_value);
          check_field("byte_pos", {3'd0, want.byte_pos}, {3'd0, out_byte_pos});
          check_field("last", {7'd0, want.last}, {7'd0, out_last});
          check_field("aborted", {7'd0, want.aborted}, {7'd0, out_aborted});
          check_field("crc_ok", {7'd0, want.crc_ok}, {7'd0, out_crc_ok});
          check_field("ack_wanted", {7'd0, want.ack_wanted}, {7'd0, out_ack_wanted});
          matched++;
        end
      end

      // input beat
      if (in_valid && !in_stall) receive_event(in_cmd, in_rx_bit);
    end

    fail_count    <= mismatches;
    results_owed  <= pending_bytes.size();
    bytes_checked <= matched;
    frame_open    <= rx_open;
  end

endmodule

/* verif/tb_stuffed_frame_bit_receiver_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stuffed_frame_bit_receiver_core
// Drives bit-stuffed frames into the receiver: a short directed opening,
// then random frames (mostly well formed, some corrupted or cut short, with
// stray idle checks and samples) under six register settings. Both channels
// idle in random bursts; a separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_stuffed_frame_bit_receiver_core;

  localparam int ID_SLOTS     = 8;
  localparam int PHASE_BEATS  = 220;
  localparam int PHASES       = 6;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic        cfg_index = sfbr_pkg::CFG_CRC_POLY;
  logic [63:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic        in_cmd = 1'b0;
  logic        in_rx_bit = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  out_byte_value;
  logic [4:0]  out_byte_pos;
  logic        out_last;
  logic        out_aborted;
  logic        out_crc_ok;
  logic        out_ack_wanted;

  int          fail_count;
  int          results_owed;
  int          bytes_checked;
  logic        frame_open;

  // stimulus bookkeeping
  logic [7:0]  poly_now = sfbr_pkg::CRC_POLY_RST;
  logic [63:0] ids_now = '0;
  bit          gap_on = 1'b0;
  bit          calm = 1'b0;
  int          beats_sent = 0;
  int          frames_sent = 0;
  int          frames_aborted = 0;
  int          settings_used = 1;

  // bit stream of the frame being built, with its stuffing run tracker
  bit          frame_bits[$];
  int          run_len;
  bit          run_bit;

  always #6 clk = ~clk;

  stuffed_frame_bit_receiver_core #(
    .ACK_ID_SLOTS(ID_SLOTS)
  ) DUT (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_rx_bit(in_rx_bit),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte_value(out_byte_value), .out_byte_pos(out_byte_pos),
    .out_last(out_last), .out_aborted(out_aborted),
    .out_crc_ok(out_crc_ok), .out_ack_wanted(out_ack_wanted)
  );

  stuffed_frame_bit_receiver_checker #(
    .ACK_ID_SLOTS(ID_SLOTS)
  ) u_checker (
    .clk(clk), .rst_n(rst_n),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_cmd(in_cmd), .in_rx_bit(in_rx_bit),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_byte_value(out_byte_value), .out_byte_pos(out_byte_pos),
    .out_last(out_last), .out_aborted(out_aborted),
    .out_crc_ok(out_crc_ok), .out_ack_wanted(out_ack_wanted),
    .fail_count(fail_count), .results_owed(results_owed),
    .bytes_checked(bytes_checked), .frame_open(frame_open)
  );

  // Run limit
  initial begin
    #5_000_000;
    $display("stuffed_frame_bit_receiver_core verification failed");
    $finish;
  end

  // Result side back-pressure: random stall bursts, none once calm
  initial begin
    while (!rst_n) @(posedge clk);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      out_stall <= 1'b0;
      repeat ($urandom_range(1, ($urandom_range(0, 5) == 0) ? 120 : 15)) @(posedge clk);
    end
  end

  // CRC used to build frames that should pass the check
  function automatic logic [7:0] frame_crc(logic [7:0] crc, logic [7:0] b);
    logic [7:0] x;
    x = crc ^ b;
    for (int n = 0; n < 8; n++) x = x[7] ? ((x << 1) ^ poly_now) : (x << 1);
    return x;
  endfunction

  // One input beat; valid stays high on return
  task automatic send_beat(input logic cmd, input logic lvl);
    if (gap_on && !calm && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_cmd    <= cmd;
    in_rx_bit <= lvl;
    do @(posedge clk); while (in_stall);
    beats_sent++;
  endtask

  // Append a byte MSB first, inserting the opposite bit after five equal bits
  task automatic add_stuffed(input logic [7:0] b);
    for (int i = 7; i >= 0; i--) begin
      if (run_len == 5) begin
        frame_bits.push_back(!run_bit);
        run_bit = !run_bit;
        run_len = 1;
      end
      frame_bits.push_back(b[i]);
      if (run_len > 0 && b[i] == run_bit) begin
        run_len++;
      end else begin
        run_bit = b[i];
        run_len = 1;
      end
    end
  endtask

  task automatic add_plain(input logic [7:0] b, input int nbits);
    for (int i = 7; i > 7 - nbits; i--) frame_bits.push_back(b[i]);
  endtask

  // Build one frame with random content and send it bit by bit
  task automatic send_frame();
    logic [7:0] len_byte;
    logic [7:0] crc;
    logic [7:0] d;
    logic [7:0] end_byte;
    int         count;
    int         cut;
    frame_bits.delete();
    run_len = 0;
    run_bit = 1'b0;
    gap_on = ($urandom_range(0, 3) != 0);

    // start field, not stuffed
    frame_bits.push_back(1'($urandom_range(0, 1)));
    frame_bits.push_back(1'($urandom_range(0, 1)));

    // length byte: mostly short frames, a few full-size ones and aborts
    if ($urandom_range(0, 9) < 6)       count = $urandom_range(0, 3);
    else if ($urandom_range(0, 7) == 0) count = $urandom_range(14, 15);
    else                                count = $urandom_range(0, 13);
    len_byte = 8'($urandom);
    len_byte[3:0] = 4'(count);
    add_stuffed(len_byte);
    crc = frame_crc(8'h00, len_byte);

    if (count > sfbr_pkg::LEN_LIMIT) begin
      frames_aborted++;
    end else begin
      for (int i = 0; i < count; i++) begin
        d = 8'($urandom);
        // first data byte often names a listed ID
        if (i == 0 && $urandom_range(0, 1) == 1) d = ids_now[8 * $urandom_range(0, 7) +: 8];
        add_stuffed(d);
        crc = frame_crc(crc, d);
      end
      if ($urandom_range(0, 3) == 0) crc = 8'($urandom);
      if (count == 0 && $urandom_range(0, 3) == 0) crc = ids_now[8 * $urandom_range(0, 7) +: 8];
      add_stuffed(crc);
      end_byte = ($urandom_range(0, 3) != 0) ? sfbr_pkg::END_MARK : 8'($urandom);
      add_plain(end_byte, 8);
      add_plain(8'($urandom), 3);
    end

    // broken frames: a flipped bit or a frame cut short
    if ($urandom_range(0, 11) == 0) begin
      cut = $urandom_range(0, frame_bits.size() - 1);
      frame_bits[cut] = !frame_bits[cut];
    end
    if ($urandom_range(0, 19) == 0) begin
      cut = $urandom_range(1, frame_bits.size());
      while (frame_bits.size() > cut) void'(frame_bits.pop_back());
    end

    // stray events on the idle bus before the frame
    if ($urandom_range(0, 3) == 0) send_beat(1'b1, 1'($urandom_range(0, 1)));
    if ($urandom_range(0, 5) == 0) send_beat(1'b0, 1'b0);

    send_beat(1'b0, 1'b1);
    foreach (frame_bits[i]) begin
      if ($urandom_range(0, 29) == 0) send_beat(1'b0, 1'($urandom_range(0, 1)));
      send_beat(1'b1, frame_bits[i]);
    end
    frames_sent++;
  endtask

  // Clock in alternating bits until the receiver is back to idle
  task automatic close_frame();
    bit lvl;
    lvl = 1'b0;
    in_valid <= 1'b0;
    @(posedge clk);
    while (frame_open) begin
      send_beat(1'b1, lvl);
      lvl = !lvl;
      in_valid <= 1'b0;
      @(posedge clk);
    end
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    do @(posedge clk); while (results_owed != 0);
  endtask

  // Register write beat; the caller lowers valid after the last one
  task automatic write_reg(input logic idx, input logic [63:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
  endtask

  task automatic retune(input logic [7:0] poly, input logic [63:0] ids);
    logic [63:0] word;
    close_frame();
    wait_drained();
    repeat (3) @(posedge clk);
    word = {$urandom, $urandom};
    word[7:0] = poly;
    write_reg(sfbr_pkg::CFG_CRC_POLY, word);
    write_reg(sfbr_pkg::CFG_ACK_IDS, ids);
    cfg_valid <= 1'b0;
    poly_now = poly;
    ids_now  = ids;
    settings_used++;
  endtask

  initial begin
    logic [7:0]  next_poly;
    logic [63:0] next_ids;
    int          target;
    int          spins;

    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // Directed opening
    send_beat(1'b1, 1'b1);             // samples on an idle bus are ignored
    send_beat(1'b1, 1'b0);
    send_beat(1'b0, 1'b0);             // low idle check keeps it idle
    send_beat(1'b0, 1'b1);             // frame start
    send_beat(1'b0, 1'b1);             // idle check while listening: no effect
    send_beat(1'b1, 1'b0);             // start field
    send_beat(1'b1, 1'b1);
    // length 0xFF: five ones, a dropped bit that extends the run, three
    // more ones (run saturates), count 15 aborts the frame
    repeat (5) send_beat(1'b1, 1'b1);
    send_beat(1'b1, 1'b1);
    repeat (3) send_beat(1'b1, 1'b1);
    send_beat(1'b1, 1'b1);             // after the abort: idle again
    frames_sent++;
    frames_aborted++;

    // Random frames under several register settings
    for (int phase = 0; phase < PHASES; phase++) begin
      if (phase > 0) begin
        case (phase)
          1: begin
            next_poly = 8'hFF;
            next_ids  = '1;
          end
          2: begin
            next_poly = 8'h00;
            next_ids  = '0;
          end
          4: begin
            next_poly = 8'h07;
            next_ids  = {$urandom, $urandom};
            next_ids[15:8] = next_ids[7:0];
          end
          default: begin
            next_poly = 8'($urandom);
            next_ids  = {$urandom, $urandom};
          end
        endcase
        retune(next_poly, next_ids);
      end
      // last setting runs with no idling on either side
      if (phase == PHASES - 1) calm = 1'b1;
      target = beats_sent + PHASE_BEATS;
      while (beats_sent < target) begin
        send_frame();
        if ($urandom_range(0, 14) == 0) wait_drained();
      end
    end

    // Drain and settle
    in_valid <= 1'b0;
    spins = 0;
    do begin
      @(posedge clk);
      spins++;
    end while (results_owed != 0 && spins < 5000);
    repeat (4) @(posedge clk);

    $display("Run covered %0d input beats in %0d frames (%0d aborted on length),",
             beats_sent, frames_sent, frames_aborted);
    $display("%0d result bytes checked across %0d register settings.",
             bytes_checked, settings_used);
    if (results_owed != 0)
      $error("%0d expected result bytes never arrived", results_owed);
    if (fail_count == 0 && results_owed == 0) begin
      $display("stuffed_frame_bit_receiver_core verification clean");
    end else begin
      $display("stuffed_frame_bit_receiver_core verification failed");
    end
    $finish;
  end

endmodule
